// ===== design/otsb_pkg.sv =====
// Shared types and codes for the one-shot timer bank.
// No dependencies; imported by otsb_cell, one_shot_timer_bank, the checker and the testbench.
`default_nettype none
package otsb_pkg;

    // request opcodes (opcode 3 is served as a status read)
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_ARMED   = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;  // take the neighbour's contents
        logic load;   // take the arm data
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/otsb_cell.sv =====
// One timer slot of the ring: remaining count, busy and notify flags.
// Depends on otsb_pkg.
`default_nettype none
module otsb_cell #(
    parameter int COUNT_BITS = 32
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  otsb_pkg::cell_ctl_t        ctl,
    input  wire                        nb_busy,
    input  wire                        nb_notify,
    input  wire  [COUNT_BITS-1:0]      nb_rem,
    input  wire                        ld_notify,
    input  wire  [COUNT_BITS-1:0]      ld_rem,
    output logic                       busy,
    output logic                       notify,
    output logic [COUNT_BITS-1:0]      rem
);
    import otsb_pkg::*;

    logic                  busy_reg,   busy_next;
    logic                  notify_reg, notify_next;
    logic [COUNT_BITS-1:0] rem_reg,    rem_next;

    always_comb begin
        busy_next   = busy_reg;
        notify_next = notify_reg;
        rem_next    = rem_reg;
        if (ctl.load) begin
            busy_next   = 1'b1;
            notify_next = ld_notify;
            rem_next    = ld_rem;
        end else if (ctl.shift) begin
            busy_next   = nb_busy;
            notify_next = nb_notify;
            rem_next    = nb_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            notify_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            notify_reg <= notify_next;
        end
        rem_reg <= rem_next;  // payload, only read while busy
    end

    assign busy   = busy_reg;
    assign notify = notify_reg;
    assign rem    = rem_reg;

endmodule
`default_nettype wire

// ===== design/one_shot_timer_bank.sv =====
// Arm and status requests give their registered result in the cycle after acceptance; a tick
// walks the ring through all SLOTS slots, then gives its status result from the final state.
// A tick holds off new requests until its walk and final status are done, as the single
// decrementer at the ring head serves the slots in turn; arm and status requests can be taken
// every cycle while results drain. Output stalls freeze the walk.
// Reset (aresetn, synchronous, active low) frees all slots and clears the ms counters.
`default_nettype none
module one_shot_timer_bank #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [31:0] s_period,
    input  wire         s_has_callback,
    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_slot,
    output logic [62:0] m_elapsed,
    output logic [1:0]  m_blink_bits,
    output logic        m_last
);
    import otsb_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINAL} state_t;

    // ---------------------------------------------------------------------------------
    // Sequencer and output registers
    // ---------------------------------------------------------------------------------
    state_t              state_reg,   state_next;
    logic [SLOT_W-1:0]   step_reg,    step_next;
    logic [9:0]          ms_reg,      ms_next;
    logic [63:0]         elapsed_reg, elapsed_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_kind_reg,  m_kind_next;
    logic [3:0]          m_slot_reg,  m_slot_next;
    logic [62:0]         m_elap_reg,  m_elap_next;
    logic [1:0]          m_blink_reg, m_blink_next;
    logic                m_last_reg,  m_last_next;

    // ring of cells; cell 0 is the head that feeds the decrementer
    cell_ctl_t           ctl      [SLOTS];
    logic                busy_q   [SLOTS];
    logic                notify_q [SLOTS];
    logic [COUNT_BITS-1:0] rem_q  [SLOTS];
    logic                sh_busy  [SLOTS];
    logic                sh_notify[SLOTS];
    logic [COUNT_BITS-1:0] sh_rem [SLOTS];
    logic [SLOTS-1:0]    busy_vec;

    logic                  out_free;
    logic                  accept;
    logic                  walk_go;
    logic                  arm_take;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [COUNT_BITS-1:0] head_dec;
    logic                  head_exp;
    logic [COUNT_BITS-1:0] ld_rem;
    logic [63:0]           period_ext;

    // slot field carries the index modulo 16
    function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+3:0] w;
        w = {4'b0000, idx};
        return w[3:0];
    endfunction

    // bit0: (ms/40) odd, via (ms>>3)/5 as a reciprocal multiply; bit1: (ms/250) odd
    function automatic logic [1:0] blink_of(input logic [9:0] ms);
        logic [14:0] prod;
        prod = 15'(ms[9:3]) * 15'd205;
        return {((ms >= 10'd250) && (ms < 10'd500)) || (ms >= 10'd750), prod[10]};
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign walk_go  = (state_reg == ST_WALK) && out_free;

    // lowest free slot; the ring is at home position whenever arms are taken
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_q[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // period saturates to the counter width
    assign period_ext = {32'd0, s_period};
    assign ld_rem     = (period_ext > CNT_MAX) ? COUNT_BITS'(CNT_MAX)
                                               : COUNT_BITS'(period_ext);
    assign arm_take   = accept && (s_opcode == OP_ARM) && (s_period != 32'd0) && free_found;

    // head processing: one decrement per walk step
    assign head_dec = rem_q[0] - COUNT_BITS'(1);
    assign head_exp = busy_q[0] && (head_dec == '0);

    // the ring turns towards the head; slot k reaches the head at step k
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_ring
            if (g == SLOTS - 1) begin : g_tail
                assign sh_busy[g]   = busy_q[0] && !head_exp;
                assign sh_notify[g] = notify_q[0] && !head_exp;
                assign sh_rem[g]    = busy_q[0] ? head_dec : rem_q[0];
            end else begin : g_mid
                assign sh_busy[g]   = busy_q[g+1];
                assign sh_notify[g] = notify_q[g+1];
                assign sh_rem[g]    = rem_q[g+1];
            end
            assign ctl[g].shift = walk_go;
            assign ctl[g].load  = arm_take && (free_idx == SLOT_W'(g));
            assign busy_vec[g]  = busy_q[g];

            otsb_cell #(
                .COUNT_BITS(COUNT_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl[g]),
                .nb_busy   (sh_busy[g]),
                .nb_notify (sh_notify[g]),
                .nb_rem    (sh_rem[g]),
                .ld_notify (s_has_callback),
                .ld_rem    (ld_rem),
                .busy      (busy_q[g]),
                .notify    (notify_q[g]),
                .rem       (rem_q[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        ms_next      = ms_reg;
        elapsed_next = elapsed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_slot_next  = m_slot_reg;
        m_elap_next  = m_elap_reg;
        m_blink_next = m_blink_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        OP_TICK: begin
                            // counters move now; the walk's results show the new values
                            ms_next      = (ms_reg == 10'd999) ? 10'd0 : ms_reg + 10'd1;
                            elapsed_next = elapsed_reg + 64'd1;
                            step_next    = '0;
                            state_next   = ST_WALK;
                        end
                        OP_ARM: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = arm_take ? KIND_ARMED : KIND_REJECT;
                            m_slot_next  = arm_take ? slot_field(free_idx) : 4'd0;
                            m_elap_next  = elapsed_reg[62:0];
                            m_blink_next = blink_of(ms_reg);
                            m_last_next  = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_STATUS;
                            m_slot_next  = 4'd0;
                            m_elap_next  = elapsed_reg[62:0];
                            m_blink_next = blink_of(ms_reg);
                            m_last_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_go) begin
                    if (head_exp && notify_q[0]) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_EXPIRED;
                        m_slot_next  = slot_field(step_reg);
                        m_elap_next  = elapsed_reg[62:0];
                        m_blink_next = blink_of(ms_reg);
                        m_last_next  = 1'b0;
                    end
                    if (step_reg == SLOT_W'(SLOTS - 1)) begin
                        step_next  = '0;
                        state_next = ST_FINAL;
                    end else begin
                        step_next = step_reg + SLOT_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_STATUS;
                    m_slot_next  = 4'd0;
                    m_elap_next  = elapsed_reg[62:0];
                    m_blink_next = blink_of(ms_reg);
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            ms_reg      <= 10'd0;
            elapsed_reg <= 64'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            ms_reg      <= ms_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
        m_kind_reg  <= m_kind_next;
        m_slot_reg  <= m_slot_next;
        m_elap_reg  <= m_elap_next;
        m_blink_reg <= m_blink_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_slot       = m_slot_reg;
    assign m_elapsed    = m_elap_reg;
    assign m_blink_bits = m_blink_reg;
    assign m_last       = m_last_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    // walk counter is parked at zero whenever the ring is at home
    a_step_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> step_reg == '0)
        else $error("walk step not at zero while idle");

    // a tick request advances the elapsed count by exactly one
    a_tick_elapsed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_opcode == OP_TICK |=> elapsed_reg == $past(elapsed_reg) + 64'd1)
        else $error("elapsed count not advanced by tick");

    // a successful arm occupies exactly one more slot
    a_arm_count: assert property (@(posedge aclk) disable iff (!aresetn)
        arm_take |=> $countones(busy_vec) == $past($countones(busy_vec)) + 1)
        else $error("arm did not take exactly one slot");

    // the walk never occupies slots
    a_walk_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |=> $countones(busy_vec) <= $past($countones(busy_vec)))
        else $error("slot became busy during walk");

    // only expiry results are followed by more results of the same request
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_last_reg |-> m_kind_reg == KIND_EXPIRED)
        else $error("non-final result of wrong kind");

endmodule
`default_nettype wire

// ===== verif/one_shot_timer_bank_checker.sv =====
// Monitor for one_shot_timer_bank: mirrors the timer bank on every accepted request
// and compares each result, in order, against the mirror. Depends on otsb_pkg.
`default_nettype none
module one_shot_timer_bank_checker #(
    parameter int SLOTS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [31:0] s_period,
    input  wire         s_has_callback,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [1:0]  m_kind,
    input  wire  [3:0]  m_slot,
    input  wire  [62:0] m_elapsed,
    input  wire  [1:0]  m_blink_bits,
    input  wire         m_last,
    output int          mismatches,
    output int          outstanding
);
    import otsb_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [62:0] elapsed;
        logic [1:0]  blink;
        logic        last;
    } timer_result_t;

    logic [31:0]      count_left [SLOTS];
    logic [SLOTS-1:0] armed;
    logic [SLOTS-1:0] wants_event;
    logic [9:0]       ms_count;
    logic [63:0]      ms_total;
    timer_result_t    due_results [$];

    task automatic queue_result(input logic [1:0] kind, input int slot, input logic last);
        timer_result_t r;
        int unsigned tens;
        tens      = ms_count / 10;
        r.kind    = kind;
        r.slot    = slot[3:0];
        r.elapsed = ms_total[62:0];
        r.blink   = {((tens / 25) % 2) == 1, ((tens / 4) % 2) == 1};
        r.last    = last;
        due_results.push_back(r);
    endtask

    task automatic run_timer_bank(input logic [1:0] op, input logic [31:0] period,
                                  input logic cb);
        int free_slot;
        free_slot = -1;
        case (op)
            OP_TICK: begin
                ms_count = (ms_count == 10'd999) ? 10'd0 : ms_count + 10'd1;
                ms_total = ms_total + 64'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (armed[i]) begin
                        count_left[i] = count_left[i] - 32'd1;
                        if (count_left[i] == 32'd0) begin
                            armed[i] = 1'b0;
                            if (wants_event[i])
                                queue_result(KIND_EXPIRED, i, 1'b0);
                            wants_event[i] = 1'b0;
                        end
                    end
                end
                queue_result(KIND_STATUS, 0, 1'b1);
            end
            OP_ARM: begin
                // lowest free slot; a zero period never takes one
                if (period != 32'd0) begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!armed[i])
                            free_slot = i;
                end
                if (free_slot < 0) begin
                    queue_result(KIND_REJECT, 0, 1'b1);
                end else begin
                    count_left[free_slot]  = period;
                    armed[free_slot]       = 1'b1;
                    wants_event[free_slot] = cb;
                    queue_result(KIND_ARMED, free_slot, 1'b1);
                end
            end
            default: queue_result(KIND_STATUS, 0, 1'b1);
        endcase
    endtask

    task automatic check_result();
        timer_result_t seen;
        timer_result_t want;
        seen = {m_kind, m_slot, m_elapsed, m_blink_bits, m_last};
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("checker: result with no request pending: kind=%0d slot=%0d elapsed=%0d blink=%0d last=%0d",
                         seen.kind, seen.slot, seen.elapsed, seen.blink, seen.last);
        end else begin
            want = due_results.pop_front();
            if (seen !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("checker: mismatch: want kind=%0d slot=%0d elapsed=%0d blink=%0d last=%0d",
                             want.kind, want.slot, want.elapsed, want.blink, want.last);
                    $display("checker:           got  kind=%0d slot=%0d elapsed=%0d blink=%0d last=%0d",
                             seen.kind, seen.slot, seen.elapsed, seen.blink, seen.last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            armed       = '0;
            wants_event = '0;
            ms_count    = '0;
            ms_total    = '0;
            due_results.delete();
        end else begin
            // results of a request only appear after it, so check first
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                run_timer_bank(s_opcode, s_period, s_has_callback);
        end
        outstanding = due_results.size();
    end

endmodule
`default_nettype wire

// ===== verif/one_shot_timer_bank_tb.sv =====
// Top of the one_shot_timer_bank testbench: clock, reset, request stimulus and
// result-side back-pressure. Depends on otsb_pkg, one_shot_timer_bank and the checker.
`default_nettype none
module one_shot_timer_bank_tb;
    import otsb_pkg::*;

    localparam int         SLOTS        = 16;
    localparam logic [1:0] OP_SPARE     = 2'd3;       // unused code, served as a status read
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = SLOTS + 4;  // a full ring walk plus margin
    localparam int         HOLD_CYCLES  = 400;        // long receiver hold-off
    localparam int         PHASE_ITEMS  = 25;         // random requests per idling phase
    localparam int         TICK_RUN     = 155;        // closing run of tick requests

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    wire         s_ready;
    logic [1:0]  s_opcode       = OP_STATUS;
    logic [31:0] s_period       = '0;
    logic        s_has_callback = 1'b0;
    wire         m_valid;
    logic        m_ready        = 1'b0;
    wire  [1:0]  m_kind;
    wire  [3:0]  m_slot;
    wire  [62:0] m_elapsed;
    wire  [1:0]  m_blink_bits;
    wire         m_last;

    int mismatches;
    int outstanding;

    // idling controls: the sender's is used only by the stimulus process, the
    // receiver's is read by the back-pressure process at the falling edge
    int idle_pct   = 0;
    int stall_pct  = 0;
    // hold-off handshake between stimulus and receiver: bump hold_asked to start one
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int cycles     = 0;

    one_shot_timer_bank #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (32)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_period       (s_period),
        .s_has_callback (s_has_callback),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_slot         (m_slot),
        .m_elapsed      (m_elapsed),
        .m_blink_bits   (m_blink_bits),
        .m_last         (m_last)
    );

    one_shot_timer_bank_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_period       (s_period),
        .s_has_callback (s_has_callback),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_slot         (m_slot),
        .m_elapsed      (m_elapsed),
        .m_blink_bits   (m_blink_bits),
        .m_last         (m_last),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result-side back-pressure. A requested hold-off is counted down here,
    // independent of the stimulus, so the sender keeps offering requests
    // while the bank backs up and drops s_ready.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request, called and returning at a falling edge. Valid is only
    // dropped for idle cycles, never lowered and raised within one step.
    task automatic send_request(input logic [1:0] op, input logic [31:0] period,
                                input logic cb);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_period       <= period;
        s_has_callback <= cb;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int          pick;
        logic [1:0]  op;
        logic [31:0] period;

        // synchronous reset held over the first rising edges, then released mid-cycle
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed requests ----
        send_request(OP_STATUS, 32'h0, 1'b0);
        send_request(OP_SPARE, 32'hFFFF_FFFF, 1'b1);    // unused code reads status
        send_request(OP_ARM, 32'h0, 1'b1);              // zero period: rejected
        send_request(OP_ARM, 32'd1, 1'b1);              // slot 0, fires on next tick
        send_request(OP_ARM, 32'd2, 1'b0);              // slot 1, silent expiry
        send_request(OP_TICK, 32'h0, 1'b0);             // slot 0 expiry reported
        send_request(OP_TICK, 32'h0, 1'b0);             // slot 1 expires quietly
        send_request(OP_ARM, 32'hFFFF_FFFF, 1'b1);      // largest period, parks slot 0
        for (int i = 1; i < SLOTS; i++)
            send_request(OP_ARM, 32'd3, 1'b1);          // fill the bank
        send_request(OP_ARM, 32'd5, 1'b0);              // full bank: rejected
        repeat (3)
            send_request(OP_TICK, 32'h0, 1'b0);         // third tick expires fifteen at once

        // ---- random requests, one idling mix per phase ----
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 46; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 46; end
                default: begin idle_pct = 32; stall_pct <= 32; end
            endcase
            // long hold-off while the sender runs flat out
            if (phase == 0)
                hold_asked <= hold_asked + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    op = OP_TICK;
                else if (pick < 85)
                    op = OP_ARM;
                else if (pick < 95)
                    op = OP_STATUS;
                else
                    op = OP_SPARE;
                // mostly short periods so slots cycle; a few full-width ones park a slot
                pick = $urandom_range(99);
                if (pick < 5)
                    period = 32'h0;
                else if (pick < 9)
                    period = $urandom;
                else if (pick < 25)
                    period = $urandom_range(200, 20);
                else
                    period = $urandom_range(20, 1);
                send_request(op, period, 1'($urandom_range(1)));
            end
        end

        // ---- tick run: drains short timers and carries the ms count through
        // several fast-blink phases ----
        idle_pct = 0;
        stall_pct <= 0;
        for (int n = 0; n < TICK_RUN; n++)
            send_request(OP_TICK, $urandom, 1'($urandom_range(1)));

        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
design/otsb_pkg.sv
design/otsb_cell.sv
design/one_shot_timer_bank.sv
verif/one_shot_timer_bank_checker.sv
verif/one_shot_timer_bank_tb.sv
